>>> src/rau_pkg.sv
package rau_pkg;

   localparam int InW  = 16;
   localparam int NumW = 33;
   localparam int DenW = 32;
   localparam int MagW = 32;
   localparam int KindW = 3;

   localparam logic [KindW-1:0] KIND_ADD = 3'd0;
   localparam logic [KindW-1:0] KIND_SUB = 3'd1;
   localparam logic [KindW-1:0] KIND_MUL = 3'd2;
   localparam logic [KindW-1:0] KIND_DIV = 3'd3;
   localparam logic [KindW-1:0] KIND_CMP = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_G1_LOAD,
      ST_G1_RUN,
      ST_L_DIV,
      ST_L_RUN,
      ST_QA_DIV,
      ST_QA_RUN,
      ST_QB_DIV,
      ST_QB_RUN,
      ST_FORM,
      ST_G2_LOAD,
      ST_G2_RUN,
      ST_RED_N,
      ST_RED_D,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic prod;
      logic gcd_den;
      logic gcd_res;
      logic gcd_step;
      logic div_l;
      logic div_qa;
      logic div_qb;
      logic div_rn;
      logic div_rd;
      logic div_step;
      logic take_l;
      logic take_qa;
      logic take_qb;
      logic form;
      logic take_rn;
      logic take_rd;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fault;
      logic is_cmp;
      logic is_addsub;
      logic gcd_done;
      logic div_done;
   } stat_type;

endpackage

>>> src/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// signed 16-bit fractions, result reduced by the gcd when both parts are positive.
// Input: drive req_* and raise start; the item is taken on a clock edge with
// start high and busy low. busy falls in the cycle in which the result is shown.
// Output: rsp_valid is high for exactly one cycle with rsp_* holding the result;
// the receiver must take it then, it cannot stall the block.
// Sequence, from the accept edge to the result:
// compare and faults go straight from the products to the output.
// Multiply/divide: one binary gcd on the result (no steps when a part is not
// positive), then two divider passes reduce numerator and denominator.
// Add/subtract first run a gcd on the denominators and three divider passes
// (L, L/|da|, L/|db|), then go on as multiply/divide. One item at a time;
// the single shared shift-subtract divider (one quotient bit a cycle) and
// the binary gcd (one step a cycle) do the work.
// Reset: synchronous, active high; returns to idle, no result pending.
module rational_arithmetic_unit_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rau_pkg::KindW-1:0]      req_kind,
   input  logic signed [rau_pkg::InW-1:0] req_num_a,
   input  logic signed [rau_pkg::InW-1:0] req_den_a,
   input  logic signed [rau_pkg::InW-1:0] req_num_b,
   input  logic signed [rau_pkg::InW-1:0] req_den_b,
   output logic                           rsp_valid,
   output logic signed [rau_pkg::NumW-1:0] rsp_res_num,
   output logic signed [rau_pkg::DenW-1:0] rsp_res_den,
   output logic                           rsp_greater,
   output logic                           rsp_less,
   output logic                           rsp_error
);
   import rau_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rau_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   rau_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_kind), .req_num_a(req_num_a), .req_den_a(req_den_a),
      .req_num_b(req_num_b), .req_den_b(req_den_b),
      .rsp_valid(rsp_valid), .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_greater(rsp_greater), .rsp_less(rsp_less), .rsp_error(rsp_error)
   );
endmodule

>>> src/rau_datapath.sv
module rau_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rau_pkg::cmd_type              cmd,
   output rau_pkg::stat_type             stat,
   input  logic [rau_pkg::KindW-1:0]     req_kind,
   input  logic signed [rau_pkg::InW-1:0] req_num_a,
   input  logic signed [rau_pkg::InW-1:0] req_den_a,
   input  logic signed [rau_pkg::InW-1:0] req_num_b,
   input  logic signed [rau_pkg::InW-1:0] req_den_b,
   output logic                          rsp_valid,
   output logic signed [rau_pkg::NumW-1:0] rsp_res_num,
   output logic signed [rau_pkg::DenW-1:0] rsp_res_den,
   output logic                          rsp_greater,
   output logic                          rsp_less,
   output logic                          rsp_error
);
   import rau_pkg::*;

   logic [KindW-1:0]      kind_ff;
   logic signed [InW-1:0] na_ff, da_ff, nb_ff, db_ff;
   logic signed [NumW-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic signed [DenW-1:0] dd_ff, dd_in;
   logic signed [NumW-1:0] n_ff, n_in;
   logic signed [DenW-1:0] d_ff, d_in;
   logic [MagW-1:0] g_ff, l_ff, qa_ff, qb_ff;
   logic [MagW-1:0] gp_ff, gp_in, gq_ff, gq_in;
   logic [MagW-1:0] dv_rem_ff, dv_rem_in, dv_quo_ff, dv_quo_in, dv_den_ff, dv_den_in;
   logic [5:0] dv_cnt_ff, dv_cnt_in;
   logic [MagW:0] dv_trial;
   logic [MagW-1:0] dv_shift;
   logic signed [NumW+1:0] sum_w;
   logic signed [NumW-1:0] ta, tb;
   logic v_ff;
   logic signed [NumW-1:0] on_ff;
   logic signed [DenW-1:0] od_ff;
   logic og_ff, ol_ff, oe_ff;
   logic gcd_act_ff, gcd_act_in;
   logic [MagW-1:0] da_mag, db_mag;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         na_ff <= req_num_a;
         da_ff <= req_den_a;
         nb_ff <= req_num_b;
         db_ff <= req_den_b;
      end
   end

   assign stat.fault = (da_ff == '0) || (db_ff == '0) || (kind_ff > KIND_CMP) ||
                       ((kind_ff == KIND_DIV) && (nb_ff == '0));
   assign stat.is_cmp = (kind_ff == KIND_CMP);
   assign stat.is_addsub = (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB);

   assign da_mag = da_ff[InW-1] ? MagW'(-MagW'(da_ff)) : MagW'(da_ff);
   assign db_mag = db_ff[InW-1] ? MagW'(-MagW'(db_ff)) : MagW'(db_ff);

   // products: p1/p2 numerator side, dd denominator
   always_comb begin
      p1_in = p1_ff;
      p2_in = p2_ff;
      dd_in = dd_ff;
      if (cmd.prod) begin
         case (kind_ff)
            KIND_MUL: begin
               p1_in = NumW'(na_ff * nb_ff);
               p2_in = '0;
               dd_in = DenW'(da_ff * db_ff);
            end
            KIND_DIV: begin
               p1_in = NumW'(na_ff * db_ff);
               p2_in = '0;
               dd_in = DenW'(da_ff * nb_ff);
            end
            default: begin
               p1_in = NumW'(na_ff * db_ff);
               p2_in = NumW'(nb_ff * da_ff);
               dd_in = DenW'(da_ff * db_ff);
            end
         endcase
      end
   end

   // binary gcd, one step a cycle
   logic [5:0] gk_ff, gk_in;
   always_comb begin
      gp_in = gp_ff;
      gq_in = gq_ff;
      gk_in = gk_ff;
      gcd_act_in = gcd_act_ff;
      if (cmd.gcd_den || cmd.gcd_res) begin
         if (cmd.gcd_den) begin
            gp_in = da_mag;
            gq_in = db_mag;
            gcd_act_in = (da_ff > 0) && (db_ff > 0);
         end else begin
            gp_in = n_ff[MagW-1:0];
            gq_in = d_ff[MagW-1:0];
            gcd_act_in = (n_ff > 0) && (d_ff > 0);
         end
         gk_in = '0;
      end else if (cmd.gcd_step && gcd_act_ff && gq_ff != '0) begin
         if (!gp_ff[0] && !gq_ff[0]) begin
            gp_in = gp_ff >> 1;
            gq_in = gq_ff >> 1;
            gk_in = gk_ff + 6'd1;
         end else if (!gp_ff[0]) begin
            gp_in = gp_ff >> 1;
         end else if (!gq_ff[0]) begin
            gq_in = gq_ff >> 1;
         end else if (gp_ff > gq_ff) begin
            gp_in = gq_ff;
            gq_in = gp_ff - gq_ff;
         end else begin
            gq_in = gq_ff - gp_ff;
         end
      end
   end
   assign stat.gcd_done = !gcd_act_ff || (gq_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         gcd_act_ff <= 1'b0;
      end else begin
         gcd_act_ff <= gcd_act_in;
      end
      gp_ff <= gp_in;
      gq_ff <= gq_in;
      gk_ff <= gk_in;
   end

   logic [MagW-1:0] gval;
   assign gval = gcd_act_ff ? MagW'(gp_ff << gk_ff) : MagW'(1);

   // l_ff/|da| : division magnitudes; dd may be negative so divide |dd|
   logic [MagW-1:0] dd_mag;
   assign dd_mag = dd_ff[DenW-1] ? MagW'(-dd_ff) : MagW'(dd_ff);

   // restoring divider, unsigned magnitudes, one bit per cycle
   logic [MagW-1:0] dv_num_sel;
   logic [MagW-1:0] dv_den_sel;
   logic dv_load;
   assign dv_load = cmd.div_l | cmd.div_qa | cmd.div_qb | cmd.div_rn | cmd.div_rd;
   always_comb begin
      dv_num_sel = '0;
      dv_den_sel = 32'd1;
      if (cmd.div_l) begin
         dv_num_sel = dd_mag;
         dv_den_sel = g_ff;
      end else if (cmd.div_qa) begin
         dv_num_sel = l_ff;
         dv_den_sel = da_mag;
      end else if (cmd.div_qb) begin
         dv_num_sel = l_ff;
         dv_den_sel = db_mag;
      end else if (cmd.div_rn) begin
         // g_ff is loaded on this same edge
         dv_num_sel = n_ff[MagW-1:0];
         dv_den_sel = gval;
      end else if (cmd.div_rd) begin
         dv_num_sel = d_ff[MagW-1:0];
         dv_den_sel = g_ff;
      end
   end

   assign dv_shift = {dv_rem_ff[MagW-2:0], dv_quo_ff[MagW-1]};
   assign dv_trial = {1'b0, dv_shift} - {1'b0, dv_den_ff};
   always_comb begin
      dv_rem_in = dv_rem_ff;
      dv_quo_in = dv_quo_ff;
      dv_den_in = dv_den_ff;
      dv_cnt_in = dv_cnt_ff;
      if (dv_load) begin
         dv_rem_in = '0;
         dv_quo_in = dv_num_sel;
         dv_den_in = dv_den_sel;
         dv_cnt_in = 6'd32;
      end else if (cmd.div_step && dv_cnt_ff != '0) begin
         dv_cnt_in = dv_cnt_ff - 6'd1;
         if (!dv_trial[MagW]) begin
            dv_rem_in = dv_trial[MagW-1:0];
            dv_quo_in = {dv_quo_ff[MagW-2:0], 1'b1};
         end else begin
            dv_rem_in = dv_shift;
            dv_quo_in = {dv_quo_ff[MagW-2:0], 1'b0};
         end
      end
   end
   assign stat.div_done = (dv_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_cnt_ff <= '0;
      end else begin
         dv_cnt_ff <= dv_cnt_in;
      end
      dv_rem_ff <= dv_rem_in;
      dv_quo_ff <= dv_quo_in;
      dv_den_ff <= dv_den_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.gcd_step && stat.gcd_done) g_ff <= gval;
      if (cmd.take_l) l_ff <= dv_quo_ff;
      if (cmd.take_qa) qa_ff <= dv_quo_ff;
      if (cmd.take_qb) qb_ff <= dv_quo_ff;
   end

   // L = |da*db|/G but sign kept: L/da, L/db use magnitudes with signs
   // l_ff holds |dd|/G (G>1 only if dd>0); sign of L = sign of dd.
   logic l_neg;
   assign l_neg = dd_ff < 0;
   assign ta = na_ff * $signed({1'b0, qa_ff[15:0]});
   assign tb = nb_ff * $signed({1'b0, qb_ff[15:0]});
   logic signed [NumW-1:0] ta_s, tb_s;
   // L/da sign = sign(L)*sign(da)
   assign ta_s = (l_neg ^ (da_ff < 0)) ? -ta : ta;
   assign tb_s = (l_neg ^ (db_ff < 0)) ? -tb : tb;
   assign sum_w = (kind_ff == KIND_ADD) ? (NumW+2)'(ta_s) + (NumW+2)'(tb_s)
                                        : (NumW+2)'(ta_s) - (NumW+2)'(tb_s);

   always_comb begin
      n_in = n_ff;
      d_in = d_ff;
      if (cmd.form) begin
         if (stat.is_addsub) begin
            n_in = NumW'(sum_w);
            d_in = l_neg ? -DenW'(l_ff) : DenW'(l_ff);
         end else begin
            n_in = p1_ff;
            d_in = dd_ff;
         end
      end else if (cmd.take_rn) begin
         n_in = n_ff[NumW-1] ? n_ff : NumW'(dv_quo_ff);
      end else if (cmd.take_rd) begin
         d_in = d_ff[DenW-1] ? d_ff : DenW'(dv_quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      dd_ff <= dd_in;
      n_ff <= n_in;
      d_ff <= d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         oe_ff <= stat.fault;
         if (stat.fault || stat.is_cmp) begin
            on_ff <= '0;
            od_ff <= '0;
         end else begin
            on_ff <= n_ff;
            od_ff <= d_ff;
         end
         og_ff <= !stat.fault && stat.is_cmp && (p1_ff > p2_ff);
         ol_ff <= !stat.fault && stat.is_cmp && (p1_ff < p2_ff);
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_res_num = on_ff;
   assign rsp_res_den = od_ff;
   assign rsp_greater = og_ff;
   assign rsp_less = ol_ff;
   assign rsp_error = oe_ff;

   dv_bound: assert property (@(posedge clock) disable iff (reset)
      dv_cnt_ff <= 6'd32) else $error("divider count out of range");
   gcd_zero: assert property (@(posedge clock) disable iff (reset)
      gcd_act_ff && !stat.gcd_done |-> gp_ff != '0) else $error("gcd operand zero");
   out_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
endmodule

>>> src/rau_ctrl.sv
module rau_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rau_pkg::stat_type  stat,
   output rau_pkg::cmd_type   cmd
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            if (stat.fault || stat.is_cmp) state_in = ST_DONE;
            else if (stat.is_addsub) state_in = ST_G1_LOAD;
            else state_in = ST_FORM;
         end
         ST_G1_LOAD: begin
            cmd.gcd_den = 1'b1;
            state_in = ST_G1_RUN;
         end
         ST_G1_RUN: begin
            cmd.gcd_step = 1'b1;
            if (stat.gcd_done) state_in = ST_L_DIV;
         end
         ST_L_DIV: begin
            cmd.div_l = 1'b1;
            state_in = ST_L_RUN;
         end
         ST_L_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.div_step = 1'b0;
               cmd.take_l = 1'b1;
               state_in = ST_QA_DIV;
            end
         end
         ST_QA_DIV: begin
            cmd.div_qa = 1'b1;
            state_in = ST_QA_RUN;
         end
         ST_QA_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.div_step = 1'b0;
               cmd.take_qa = 1'b1;
               state_in = ST_QB_DIV;
            end
         end
         ST_QB_DIV: begin
            cmd.div_qb = 1'b1;
            state_in = ST_QB_RUN;
         end
         ST_QB_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.div_step = 1'b0;
               cmd.take_qb = 1'b1;
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = ST_G2_LOAD;
         end
         ST_G2_LOAD: begin
            cmd.gcd_res = 1'b1;
            state_in = ST_G2_RUN;
         end
         ST_G2_RUN: begin
            cmd.gcd_step = 1'b1;
            if (stat.gcd_done) begin
               cmd.div_rn = 1'b1;
               state_in = ST_RED_N;
            end
         end
         ST_RED_N: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.div_step = 1'b0;
               cmd.take_rn = 1'b1;
               cmd.div_rd = 1'b1;
               state_in = ST_RED_D;
            end
         end
         ST_RED_D: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.div_step = 1'b0;
               cmd.take_rd = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   emit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == ST_IDLE) else $error("emit not followed by idle");
   no_start: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.capture) else $error("capture while busy");
   one_load: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.div_l, cmd.div_qa, cmd.div_qb, cmd.div_rn, cmd.div_rd}) <= 1)
      else $error("divider loaded twice");
endmodule

>>> tb/rau_checker.sv
module rau_checker
   import rau_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [KindW-1:0]        req_kind,
   input  logic signed [InW-1:0]   req_num_a,
   input  logic signed [InW-1:0]   req_den_a,
   input  logic signed [InW-1:0]   req_num_b,
   input  logic signed [InW-1:0]   req_den_b,
   input  logic                    rsp_valid,
   input  logic signed [NumW-1:0]  rsp_res_num,
   input  logic signed [DenW-1:0]  rsp_res_den,
   input  logic                    rsp_greater,
   input  logic                    rsp_less,
   input  logic                    rsp_error,
   output int                      fail_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [NumW-1:0] res_num;
      logic signed [DenW-1:0] res_den;
      logic                   greater;
      logic                   less;
      logic                   error;
   } fraction_result_type;

   fraction_result_type expected_fractions[$];

   initial fail_count = 0;
   assign pending_count = expected_fractions.size();

   function automatic longint reduce_divisor(longint x, longint y);
      longint p, q, t;
      if (x <= 0 || y <= 0) return 1;
      p = x;
      q = y;
      while (q != 0) begin
         t = p % q;
         p = q;
         q = t;
      end
      return p;
   endfunction

   function automatic fraction_result_type compute_fraction(logic [KindW-1:0] kind,
         longint na, longint da, longint nb, longint db);
      fraction_result_type r;
      longint n, d, g, l;
      r = '0;
      n = 0;
      d = 0;
      if (da == 0 || db == 0 || kind > KIND_CMP || (kind == KIND_DIV && nb == 0)) begin
         r.error = 1'b1;
      end else if (kind == KIND_CMP) begin
         r.greater = (na * db) > (nb * da);
         r.less    = (na * db) < (nb * da);
      end else begin
         case (kind)
            KIND_ADD, KIND_SUB: begin
               l = (da * db) / reduce_divisor(da, db);
               if (kind == KIND_ADD) n = na * (l / da) + nb * (l / db);
               else n = na * (l / da) - nb * (l / db);
               d = l;
            end
            KIND_MUL: begin
               n = na * nb;
               d = da * db;
            end
            default: begin
               n = na * db;
               d = da * nb;
            end
         endcase
         g = reduce_divisor(n, d);
         n = n / g;
         d = d / g;
         r.res_num = n[NumW-1:0];
         r.res_den = d[DenW-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset) begin
         if (start && !busy)
            expected_fractions.push_back(compute_fraction(req_kind, req_num_a,
               req_den_a, req_num_b, req_den_b));
         if (rsp_valid) begin
            if (expected_fractions.size() == 0) begin
               $display("%0t: result with no item outstanding", $time);
               fail_count++;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_res_num !== want.res_num)
                  report_mismatch("res_num", rsp_res_num, want.res_num);
               if (rsp_res_den !== want.res_den)
                  report_mismatch("res_den", rsp_res_den, want.res_den);
               if (rsp_greater !== want.greater)
                  report_mismatch("greater", rsp_greater, want.greater);
               if (rsp_less !== want.less)
                  report_mismatch("less", rsp_less, want.less);
               if (rsp_error !== want.error)
                  report_mismatch("error", rsp_error, want.error);
            end
         end
      end
   end
endmodule

>>> tb/tb_rational_arithmetic_unit_core.sv
module tb_rational_arithmetic_unit_core;
   import rau_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KindW-1:0]        req_kind = KIND_ADD;
   logic signed [InW-1:0]   req_num_a = '0;
   logic signed [InW-1:0]   req_den_a = '0;
   logic signed [InW-1:0]   req_num_b = '0;
   logic signed [InW-1:0]   req_den_b = '0;
   logic                    rsp_valid;
   logic signed [NumW-1:0]  rsp_res_num;
   logic signed [DenW-1:0]  rsp_res_den;
   logic                    rsp_greater, rsp_less, rsp_error;
   int fail_count, pending_count;
   int idle_cycles = 0;
   int sent_per_kind[8];
   int results_seen = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rational_arithmetic_unit_core dut (.*);

   rau_checker checker_i (.*);

   always @(posedge clock) begin
      if (rsp_valid) results_seen++;
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("watchdog expired after %0d quiet cycles", idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // Drive one item at the falling edge and hold it until taken.
   task automatic send_item(logic [KindW-1:0] k, logic signed [InW-1:0] na,
         logic signed [InW-1:0] da, logic signed [InW-1:0] nb,
         logic signed [InW-1:0] db);
      req_kind  <= k;
      req_num_a <= na;
      req_den_a <= da;
      req_num_b <= nb;
      req_den_b <= db;
      start     <= 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      sent_per_kind[k]++;
      @(negedge clock);
   endtask

   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic signed [InW-1:0] pick_value(bit allow_zero);
      logic signed [InW-1:0] v;
      case ($urandom_range(0, 3))
         0: v = InW'($urandom);
         1: v = $signed(InW'($urandom_range(0, 40))) - 16'sd8;
         2: v = InW'($urandom_range(1, 300) * (($urandom_range(0, 1)) ? 1 : -1));
         default: v = InW'($urandom_range(1, 64) * $urandom_range(1, 12));
      endcase
      if (!allow_zero && v == 0) v = 1;
      return v;
   endfunction

   initial begin
      logic [KindW-1:0] k;
      int burst;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, each operation, faults, non-positive parts.
      send_item(KIND_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      send_item(KIND_ADD, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768);
      send_item(KIND_SUB, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
      send_item(KIND_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
      send_item(KIND_MUL, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_item(KIND_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
      send_item(KIND_MUL, 16'sd6, 16'sd8, 16'sd4, 16'sd9);
      send_item(KIND_DIV, 16'sd6, 16'sd8, 16'sd9, 16'sd4);
      send_item(KIND_DIV, -16'sd32768, 16'sd32767, -16'sd1, -16'sd32768);
      send_item(KIND_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd3);
      send_item(KIND_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
      send_item(KIND_CMP, -16'sd32768, 16'sd1, 16'sd32767, 16'sd1);
      send_item(KIND_CMP, 16'sd32767, -16'sd32768, -16'sd1, 16'sd32767);
      send_item(KIND_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
      send_item(KIND_CMP, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
      send_item(KIND_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_item(3'd5, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
      send_item(3'd6, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
      send_item(3'd7, 16'sd2, 16'sd3, 16'sd4, 16'sd5);
      send_item(KIND_ADD, -16'sd4, 16'sd6, 16'sd2, -16'sd6);
      send_item(KIND_SUB, 16'sd0, 16'sd5, 16'sd0, 16'sd10);
      send_item(KIND_MUL, -16'sd6, 16'sd8, 16'sd4, 16'sd9);
      send_item(KIND_DIV, 16'sd4, -16'sd9, 16'sd6, 16'sd8);
      idle_for(1);

      // Hold off until every result is back.
      while (pending_count != 0) @(negedge clock);
      idle_for(7);

      for (int i = 0; i < 1900; ) begin
         burst = $urandom_range(1, 12);
         for (int j = 0; j < burst; j++, i++) begin
            k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_item(k, pick_value(1'b1), pick_value($urandom_range(0, 24) == 0),
               ($urandom_range(0, 15) == 0) ? 16'sd0 : pick_value(1'b1),
               pick_value($urandom_range(0, 24) == 0));
         end
         if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
         if (i > 900 && i < 913) begin
            idle_for(1);
            while (pending_count != 0) @(negedge clock);
         end
      end
      start <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (300) @(posedge clock);

      $display("Covered %0d items: add %0d, sub %0d, mul %0d, div %0d, cmp %0d",
         sent_per_kind.sum(), sent_per_kind[0], sent_per_kind[1], sent_per_kind[2],
         sent_per_kind[3], sent_per_kind[4]);
      $display("Undefined operations %0d, results checked %0d",
         sent_per_kind[5] + sent_per_kind[6] + sent_per_kind[7], results_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
